FILE: hdl/cvu_pkg.sv
// ----------------------------------------------------------------------------
// cvu_pkg
// Types, character codes and helpers shared by the value unquoter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cvu_pkg;

  localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
  localparam logic [7:0] CHAR_SQUOTE    = 8'h27;
  localparam logic [7:0] CHAR_HASH      = 8'h23;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_SPACE     = 8'h20;
  localparam logic [7:0] CHAR_TAB       = 8'h09;
  localparam logic [7:0] CHAR_CR        = 8'h0D;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_MALFORMED = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_EMIT     = 6'b000010,
    ST_FLUSH_RD = 6'b000100,
    ST_FLUSH_WR = 6'b001000,
    ST_BYTE     = 6'b010000,
    ST_STATUS   = 6'b100000
  } cvu_state_t;

  typedef struct packed {
    logic load;
    logic push_space;
    logic flush_setup;
    logic flush_out;
    logic byte_out;
    logic status_out;
  } cvu_cmd_t;

  typedef struct packed {
    logic op_any;
    logic op_ws;
    logic op_more;
    logic end_flag;
    logic flush_empty;
    logic flush_last;
    logic out_free;
  } cvu_stat_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

endpackage

`default_nettype wire

FILE: hdl/cvu_ctrl.sv
// ----------------------------------------------------------------------------
// cvu_ctrl
// Sequencer that steps each item through emission, flush and status.
// ----------------------------------------------------------------------------
`default_nettype none

module cvu_ctrl
  import cvu_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire cvu_stat_t stat,
  output cvu_cmd_t       cmd
);

  cvu_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!stat.op_any) begin
          state_nxt = stat.end_flag ? ST_STATUS : ST_IDLE;
        end else if (stat.op_ws) begin
          cmd.push_space = 1'b1;
        end else begin
          cmd.flush_setup = 1'b1;
          state_nxt = stat.flush_empty ? ST_BYTE : ST_FLUSH_RD;
        end
      end
      ST_FLUSH_RD: begin
        state_nxt = ST_FLUSH_WR;
      end
      ST_FLUSH_WR: begin
        if (stat.out_free) begin
          cmd.flush_out = 1'b1;
          state_nxt = stat.flush_last ? ST_BYTE : ST_FLUSH_RD;
        end
      end
      ST_BYTE: begin
        if (stat.out_free) begin
          cmd.byte_out = 1'b1;
          if (stat.op_more) begin
            state_nxt = ST_EMIT;
          end else if (stat.end_flag) begin
            state_nxt = ST_STATUS;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_STATUS: begin
        if (stat.out_free) begin
          cmd.status_out = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/cvu_dpath.sv
// ----------------------------------------------------------------------------
// cvu_dpath
// Quote and escape flags, pending whitespace memory and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cvu_dpath
  import cvu_pkg::*;
#(
  parameter int PENDING_DEPTH = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] in_char,
  input  wire logic       in_has_char,
  input  wire logic       in_end_of_value,
  input  wire cvu_cmd_t   cmd,
  output cvu_stat_t       stat,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_char,
  output logic            out_is_status,
  output logic [1:0]      out_status
);

  localparam int CW = $clog2(PENDING_DEPTH + 2);
  localparam int AW = $clog2(PENDING_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(PENDING_DEPTH);

  logic [7:0] mem [PENDING_DEPTH];
  logic [7:0] rd_data_r;

  logic sq_r, dq_r, esc_r, eal_r, after_sp_r, seen_r, emitted_r, cmt_r, ovf_r;
  logic sq_nxt, dq_nxt, esc_nxt, eal_nxt, after_sp_nxt, seen_nxt, cmt_nxt;
  logic bs_nxt, ce_nxt;
  logic pend_bs_r, pend_c_r, end_r;
  logic [7:0] char_r;
  logic [CW-1:0] count_r, flush_idx_r, flush_lim;
  logic [7:0] cur_byte;
  logic out_valid_r, out_is_status_r;
  logic [7:0] out_char_r;
  logic [1:0] out_status_r;
  logic sp, out_free;

  // Decode of the arriving byte against the current quote and escape flags.
  always_comb begin
    sp           = is_ws(in_char);
    sq_nxt       = sq_r;
    dq_nxt       = dq_r;
    esc_nxt      = esc_r;
    eal_nxt      = eal_r;
    after_sp_nxt = after_sp_r;
    seen_nxt     = seen_r;
    cmt_nxt      = cmt_r;
    bs_nxt       = 1'b0;
    ce_nxt       = 1'b0;
    if (in_has_char && !cmt_r && !(!seen_r && sp)) begin
      seen_nxt = 1'b1;
      priority if (sq_r) begin
        if (in_char == CHAR_SQUOTE) begin
          sq_nxt = 1'b0;
        end else begin
          ce_nxt = 1'b1;
        end
      end else if (dq_r) begin
        if (in_char == CHAR_DQUOTE) begin
          if (esc_r) begin
            ce_nxt  = 1'b1;
            esc_nxt = 1'b0;
          end else begin
            dq_nxt = 1'b0;
          end
        end else if (in_char == CHAR_BACKSLASH) begin
          if (esc_r) begin
            ce_nxt  = 1'b1;
            esc_nxt = 1'b0;
          end else begin
            esc_nxt = 1'b1;
          end
        end else begin
          bs_nxt  = esc_r;
          esc_nxt = 1'b0;
          ce_nxt  = 1'b1;
        end
      end else begin
        if (in_char == CHAR_DQUOTE || in_char == CHAR_SQUOTE) begin
          if (esc_r) begin
            ce_nxt  = 1'b1;
            esc_nxt = 1'b0;
          end else if (in_char == CHAR_DQUOTE) begin
            dq_nxt = 1'b1;
          end else begin
            sq_nxt = 1'b1;
          end
        end else if (in_char == CHAR_HASH) begin
          if (!after_sp_r) begin
            ce_nxt = 1'b1;
          end else begin
            cmt_nxt = 1'b1;
          end
        end else if (in_char == CHAR_BACKSLASH) begin
          if (esc_r) begin
            ce_nxt  = 1'b1;
            esc_nxt = 1'b0;
          end else begin
            esc_nxt = 1'b1;
          end
        end else begin
          ce_nxt       = 1'b1;
          after_sp_nxt = sp;
          esc_nxt      = 1'b0;
        end
      end
      if (!sp) begin
        eal_nxt = esc_nxt;
      end
    end
  end

  assign cur_byte  = pend_bs_r ? CHAR_BACKSLASH : char_r;
  assign flush_lim = (count_r > DEPTH_C) ? DEPTH_C : count_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    stat             = '0;
    stat.op_any      = pend_bs_r || pend_c_r;
    stat.op_ws       = is_ws(cur_byte);
    stat.op_more     = pend_bs_r && pend_c_r;
    stat.end_flag    = end_r;
    stat.flush_empty = (flush_lim == '0);
    stat.flush_last  = (CW'(flush_idx_r + 1'b1) == flush_lim);
    stat.out_free    = out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.status_out) begin
      sq_r       <= 1'b0;
      dq_r       <= 1'b0;
      esc_r      <= 1'b0;
      eal_r      <= 1'b0;
      after_sp_r <= 1'b0;
      seen_r     <= 1'b0;
      emitted_r  <= 1'b0;
      cmt_r      <= 1'b0;
      ovf_r      <= 1'b0;
      count_r    <= '0;
      pend_bs_r  <= 1'b0;
      pend_c_r   <= 1'b0;
      end_r      <= 1'b0;
    end else begin
      if (cmd.load) begin
        sq_r       <= sq_nxt;
        dq_r       <= dq_nxt;
        esc_r      <= esc_nxt;
        eal_r      <= eal_nxt;
        after_sp_r <= after_sp_nxt;
        seen_r     <= seen_nxt;
        cmt_r      <= cmt_nxt;
        pend_bs_r  <= bs_nxt;
        pend_c_r   <= ce_nxt;
        end_r      <= in_end_of_value;
      end
      if (cmd.push_space) begin
        if (emitted_r) begin
          count_r <= (count_r < DEPTH_C) ? CW'(count_r + 1'b1) : CW'(DEPTH_C + 1'b1);
        end
      end
      if (cmd.flush_setup && (count_r > DEPTH_C)) begin
        ovf_r <= 1'b1;
      end
      if (cmd.byte_out) begin
        count_r   <= '0;
        emitted_r <= 1'b1;
      end
      if (cmd.push_space || cmd.byte_out) begin
        if (pend_bs_r) begin
          pend_bs_r <= 1'b0;
        end else begin
          pend_c_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      char_r <= in_char;
    end
    if (cmd.flush_setup) begin
      flush_idx_r <= '0;
    end else if (cmd.flush_out) begin
      flush_idx_r <= CW'(flush_idx_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_space && emitted_r && (count_r < DEPTH_C)) begin
      mem[count_r[AW-1:0]] <= cur_byte;
    end
    rd_data_r <= mem[flush_idx_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.flush_out || cmd.byte_out || cmd.status_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.flush_out) begin
      out_char_r      <= rd_data_r;
      out_is_status_r <= 1'b0;
      out_status_r    <= STATUS_OK;
    end else if (cmd.byte_out) begin
      out_char_r      <= cur_byte;
      out_is_status_r <= 1'b0;
      out_status_r    <= STATUS_OK;
    end else if (cmd.status_out) begin
      out_char_r      <= 8'h00;
      out_is_status_r <= 1'b1;
      if (sq_r || dq_r || eal_r) begin
        out_status_r <= STATUS_MALFORMED;
      end else if (ovf_r) begin
        out_status_r <= STATUS_OVERFLOW;
      end else begin
        out_status_r <= STATUS_OK;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char      = out_char_r;
  assign out_is_status = out_is_status_r;
  assign out_status    = out_status_r;

endmodule

`default_nettype wire

FILE: hdl/config_value_unquoter_unit.sv
// ----------------------------------------------------------------------------
// config_value_unquoter_unit
// Rewrites a configuration value one character at a time, resolving quotes,
// escapes and comments and trimming whitespace, then reports a status item.
//
//   Channel | Ports                                      | Direction
//   input   | in_valid, in_stall, in_char, in_has_char,  | into block
//           | in_end_of_value                            |
//   result  | out_valid, out_stall, out_char,            | out of block
//           | out_is_status, out_status                  |
//
// Each held whitespace byte flushed ahead of an emitted byte is read back
// through the pending memory read port. Items are processed one at a time
// by the controller. Reset is synchronous and clears the parsing flags, the
// pending count and the result valid; the pending memory keeps its contents.
// A stall on the result channel holds the output register and pauses the
// controller whenever it has a result to write.
// ----------------------------------------------------------------------------
`default_nettype none

module config_value_unquoter_unit
  import cvu_pkg::*;
#(
  parameter int PENDING_DEPTH = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char,
  input  wire logic       in_has_char,
  input  wire logic       in_end_of_value,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_char,
  output logic            out_is_status,
  output logic [1:0]      out_status
);

  cvu_cmd_t  cmd;
  cvu_stat_t stat;

  cvu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  cvu_dpath #(
    .PENDING_DEPTH (PENDING_DEPTH)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_char         (in_char),
    .in_has_char     (in_has_char),
    .in_end_of_value (in_end_of_value),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char        (out_char),
    .out_is_status   (out_is_status),
    .out_status      (out_status)
  );

endmodule

`default_nettype wire

FILE: hdl/cvu_checker.sv
// ----------------------------------------------------------------------------
// cvu_checker
// Port-level checks on the input and result channels of the value unquoter.
// ----------------------------------------------------------------------------
`default_nettype none

module cvu_checker
  import cvu_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_char,
  input wire logic       out_is_status,
  input wire logic [1:0] out_status
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_char) &&
    $stable(out_is_status) && $stable(out_status))
    else $error("stalled result changed");

  a_status_zero_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_status |-> out_char == 8'h00 &&
    (out_status == STATUS_OK || out_status == STATUS_MALFORMED ||
     out_status == STATUS_OVERFLOW))
    else $error("status item carries a byte or a bad code");

  a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_status |-> out_status == STATUS_OK)
    else $error("byte item carries a status code");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken before the first was processed");

endmodule

bind config_value_unquoter_unit cvu_checker u_cvu_checker (.*);

`default_nettype wire
